FILE: rtl/audio_dma_descriptor_ring_producer_core_macros.svh
// Assertion helpers shared by the descriptor ring producer RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef AUDIO_DMA_DESCRIPTOR_RING_PRODUCER_CORE_MACROS_SVH
`define AUDIO_DMA_DESCRIPTOR_RING_PRODUCER_CORE_MACROS_SVH

// Invariant checked at every clock edge out of reset.
`define ADRP_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define ADRP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ADRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/adrp_pkg.sv
// ----------------------------------------------------------------------------
// adrp_pkg
// Types and codes shared by the descriptor ring producer front end, its
// command queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package adrp_pkg;

  // Request codes on the input channel
  localparam logic [1:0] MODE_START    = 2'd0;
  localparam logic [1:0] MODE_WRITE    = 2'd1;
  localparam logic [1:0] MODE_PROGRESS = 2'd2;
  localparam logic [1:0] MODE_STOP     = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Command queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] byte_count;
    logic [4:0]  current_index;
    logic [15:0] position_remaining;
    logic        engine_halted;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] accepted_bytes;
    logic        commit_valid;
    logic [4:0]  commit_slot;
    logic [14:0] commit_samples;
    logic        ack_boundary;
    logic        lvi_write_valid;
    logic [4:0]  lvi_value;
    logic        start_engine;
    logic        reset_engine;
    logic [5:0]  queued_count;
    logic        engine_running;
  } out_t;

  // Classified command as carried from front end to back end
  typedef enum logic [2:0] {
    OP_START,
    OP_WRITE,
    OP_WRITE_BAD,
    OP_PROGRESS,
    OP_STOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] bytes;
    logic [4:0]  civ;
    logic        halted;
    logic        picb_zero;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

`default_nettype wire

FILE: rtl/audio_dma_descriptor_ring_producer_core.sv
// ----------------------------------------------------------------------------
// audio_dma_descriptor_ring_producer_core
// Producer side of a playback descriptor ring feeding a bus-master DMA engine.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (start, write bytes, progress report, stop) enter on the in_
//   channel; each gives exactly one result on the out_ channel, in order.
//   A transfer happens on a channel when valid is high and stall is low.
//   Each request is held in the command queue and its result is then
//   registered in the output register when the output is free.
//   Throughput: one request per cycle sustained while out_stall is low. The
//   front end classifies the request in the cycle it arrives; the back end
//   updates the ring pointers and counters as it takes each command.
//   A four-entry command queue sits between the two. When out_stall holds,
//   the result stays in the output register, the queue absorbs up to four
//   more requests, and then in_stall rises until the receiver drains.
//   Reset clears the queue, the output valid flag and all ring state; the
//   stream is inactive and no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_dma_descriptor_ring_producer_core #(
  parameter int RING_SLOTS = 32,
  parameter int SLOT_BYTES = 32768
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire adrp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output adrp_pkg::out_t      out_data
);
  import adrp_pkg::*;

  qstat_t qstat;
  logic   push;
  logic   pop;
  cmd_t   push_cmd;
  cmd_t   pop_cmd;

  adrp_front #(
    .RING_SLOTS (RING_SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .qstat    (qstat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  adrp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .qstat    (qstat)
  );

  adrp_back #(
    .RING_SLOTS (RING_SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .cmd       (pop_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/adrp_front.sv
// ----------------------------------------------------------------------------
// adrp_front
// Accepts requests and classifies them: decodes the mode, checks the write
// byte count, folds the engine index into the ring and flags an empty
// position count.
// ----------------------------------------------------------------------------
`default_nettype none

module adrp_front #(
  parameter int RING_SLOTS = 32,
  parameter int SLOT_BYTES = 32768
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire adrp_pkg::in_t    in_data,
  input  wire adrp_pkg::qstat_t qstat,
  output logic                  push,
  output adrp_pkg::cmd_t        push_cmd
);
  import adrp_pkg::*;

  function automatic logic [31:0][4:0] build_wrap();
    logic [31:0][4:0] t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 5'(i % RING_SLOTS);
    end
    return t;
  endfunction

  localparam logic [31:0][4:0] CIV_WRAP = build_wrap();

  logic bytes_ok;

  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  assign bytes_ok = (in_data.byte_count != 16'd0) && (in_data.byte_count[1:0] == 2'b00) &&
                    ({16'd0, in_data.byte_count} <= 32'(SLOT_BYTES));

  always_comb begin
    push_cmd.bytes     = in_data.byte_count;
    push_cmd.civ       = CIV_WRAP[in_data.current_index];
    push_cmd.halted    = in_data.engine_halted;
    push_cmd.picb_zero = (in_data.position_remaining == 16'd0);
    unique case (in_data.mode)
      MODE_START:    push_cmd.op = OP_START;
      MODE_WRITE:    push_cmd.op = bytes_ok ? OP_WRITE : OP_WRITE_BAD;
      MODE_PROGRESS: push_cmd.op = OP_PROGRESS;
      MODE_STOP:     push_cmd.op = OP_STOP;
    endcase
  end

  // clk and rst_n are carried for the assertions below
  `include "audio_dma_descriptor_ring_producer_core_macros.svh"

  `ADRP_ASSERT_IMPLIES(a_front_push_not_full, push, !qstat.full, "push into a full queue")
  `ADRP_ASSERT_IMPLIES(a_front_civ_wrapped, push, (32'(push_cmd.civ) < 32'(RING_SLOTS)), "index not wrapped")
  `ADRP_ASSERT_IMPLIES(a_front_bad_write, push && (in_data.mode == MODE_WRITE) && !bytes_ok, push_cmd.op == OP_WRITE_BAD, "bad write not flagged")

endmodule

`default_nettype wire

FILE: rtl/adrp_queue.sv
// ----------------------------------------------------------------------------
// adrp_queue
// Short command queue between front end and back end so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module adrp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire adrp_pkg::cmd_t   push_cmd,
  input  wire logic             pop,
  output adrp_pkg::cmd_t        pop_cmd,
  output adrp_pkg::qstat_t      qstat
);
  import adrp_pkg::*;

  cmd_t           slots_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] count_r;

  assign qstat.empty = (count_r == QCW'(0));
  assign qstat.full  = (count_r == QCW'(QDEPTH));
  assign pop_cmd     = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCW'(1);
      end
    end
  end

  `include "audio_dma_descriptor_ring_producer_core_macros.svh"

  `ADRP_ASSERT_HOLDS(a_queue_count_range, count_r <= QCW'(QDEPTH), "queue count overflow")
  `ADRP_ASSERT_IMPLIES(a_queue_pop_nonempty, pop, !qstat.empty, "pop from an empty queue")
  `ADRP_ASSERT_NEXT(a_queue_count_grow, push && !pop, count_r == $past(count_r) + QCW'(1), "count did not advance")

endmodule

`default_nettype wire

FILE: rtl/adrp_back.sv
// ----------------------------------------------------------------------------
// adrp_back
// Carries out queued commands against the ring state: fills and commits
// slots, starts and feeds the engine, retires played slots, and holds each
// result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module adrp_back #(
  parameter int RING_SLOTS = 32,
  parameter int SLOT_BYTES = 32768
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire adrp_pkg::qstat_t qstat,
  input  wire adrp_pkg::cmd_t   cmd,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output adrp_pkg::out_t        out_data
);
  import adrp_pkg::*;

  localparam int SW  = $clog2(RING_SLOTS);
  localparam int SW1 = SW + 1;
  localparam int CW  = $clog2(RING_SLOTS + 1);
  localparam int FW  = $clog2(SLOT_BYTES + 1);
  localparam int BW  = (FW > 16) ? FW + 1 : 17;
  localparam logic [14:0] FULL_SAMPLES = 15'((SLOT_BYTES >> 1) & 32'h7fff);

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SW'(RING_SLOTS - 1)) ? '0 : s + SW'(1);
  endfunction

  function automatic logic [SW-1:0] prev_slot(input logic [SW-1:0] s);
    return (s == '0) ? SW'(RING_SLOTS - 1) : s - SW'(1);
  endfunction

  logic          active_r,  active_nxt;
  logic          running_r, running_nxt;
  logic [SW-1:0] retire_r,  retire_nxt;
  logic [SW-1:0] fslot_r,   fslot_nxt;
  logic [CW-1:0] queued_r,  queued_nxt;
  logic [FW-1:0] fill_r,    fill_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r,  res;

  logic [BW-1:0]  room, b_x, left;
  logic [31:0]    fill_x;
  logic [SW-1:0]  civ_s, span, tail;
  logic [SW1-1:0] d_raw, rsum;
  logic [CW-1:0]  dist_c;

  assign pop       = !qstat.empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    active_nxt  = active_r;
    running_nxt = running_r;
    retire_nxt  = retire_r;
    fslot_nxt   = fslot_r;
    queued_nxt  = queued_r;
    fill_nxt    = fill_r;
    res         = '0;
    room        = BW'(SLOT_BYTES) - BW'(fill_r);
    b_x         = BW'(cmd.bytes);
    left        = '0;
    fill_x      = 32'(fill_r);
    civ_s       = SW'(cmd.civ);
    d_raw       = SW1'(civ_s) - SW1'(retire_r);
    span        = '0;
    dist_c      = '0;
    rsum        = '0;
    tail        = '0;
    unique case (cmd.op)
      OP_START: begin
        active_nxt       = 1'b1;
        running_nxt      = 1'b0;
        retire_nxt       = '0;
        fslot_nxt        = '0;
        queued_nxt       = '0;
        fill_nxt         = '0;
        res.reset_engine = 1'b1;
      end
      OP_WRITE_BAD: begin
        res.status = ST_INVALID;
      end
      OP_WRITE: begin
        if (!active_r) begin
          res.status = ST_INVALID;
        end else if (queued_r == CW'(RING_SLOTS)) begin
          res.status = ST_FULL;
        end else if (b_x >= room) begin
          // slot completes: commit it, then place any remainder in the next unless the ring is now full
          res.commit_valid   = 1'b1;
          res.commit_slot    = 5'(fslot_r);
          res.commit_samples = FULL_SAMPLES;
          queued_nxt         = queued_r + CW'(1);
          fslot_nxt          = next_slot(fslot_r);
          fill_nxt           = '0;
          left               = b_x - room;
          res.accepted_bytes = cmd.bytes;
          if (running_r) begin
            res.ack_boundary    = 1'b1;
            res.lvi_write_valid = 1'b1;
            res.lvi_value       = 5'(fslot_r);
            res.start_engine    = cmd.halted;
          end else if (queued_nxt == CW'(RING_SLOTS)) begin
            res.lvi_write_valid = 1'b1;
            res.lvi_value       = 5'(RING_SLOTS - 1);
            res.start_engine    = 1'b1;
            running_nxt         = 1'b1;
          end
          if (left != '0) begin
            if (queued_nxt == CW'(RING_SLOTS)) begin
              res.status         = ST_FULL;
              res.accepted_bytes = 16'(room);
            end else begin
              fill_nxt = FW'(left);
            end
          end
        end else begin
          fill_nxt           = FW'(BW'(fill_r) + b_x);
          res.accepted_bytes = cmd.bytes;
        end
      end
      OP_PROGRESS: begin
        if (civ_s < retire_r) begin
          d_raw = d_raw + SW1'(RING_SLOTS);
        end
        span   = d_raw[SW-1:0];
        dist_c = (CW'(span) > queued_r) ? queued_r : CW'(span);
        rsum   = SW1'(retire_r) + SW1'(dist_c);
        if (rsum >= SW1'(RING_SLOTS)) begin
          rsum = rsum - SW1'(RING_SLOTS);
        end
        queued_nxt = queued_r - dist_c;
        retire_nxt = rsum[SW-1:0];
        // halted on an exhausted descriptor: that one is done too
        if ((queued_nxt != '0) && cmd.halted && cmd.picb_zero) begin
          queued_nxt = queued_nxt - CW'(1);
          retire_nxt = next_slot(retire_nxt);
        end
      end
      OP_STOP: begin
        if (!active_r) begin
          res.status = ST_INVALID;
        end else begin
          if (fill_r != '0) begin
            if (queued_r != CW'(RING_SLOTS)) begin
              res.commit_valid   = 1'b1;
              res.commit_slot    = 5'(fslot_r);
              res.commit_samples = fill_x[15:1];
              queued_nxt         = queued_r + CW'(1);
              fslot_nxt          = next_slot(fslot_r);
              if (running_r) begin
                res.ack_boundary = 1'b1;
                res.start_engine = cmd.halted;
              end
            end
            fill_nxt = '0;
          end
          if (queued_nxt != '0) begin
            tail                = prev_slot(fslot_nxt);
            res.lvi_write_valid = 1'b1;
            res.lvi_value       = 5'(tail);
            if (!running_r) begin
              res.start_engine = 1'b1;
              running_nxt      = 1'b1;
            end
          end
          active_nxt = 1'b0;
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
    res.queued_count   = 6'(queued_nxt);
    res.engine_running = running_nxt;
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      running_r   <= 1'b0;
      retire_r    <= '0;
      fslot_r     <= '0;
      queued_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        active_r  <= active_nxt;
        running_r <= running_nxt;
        retire_r  <= retire_nxt;
        fslot_r   <= fslot_nxt;
        queued_r  <= queued_nxt;
        fill_r    <= fill_nxt;
      end
    end
  end

  `include "audio_dma_descriptor_ring_producer_core_macros.svh"

  `ADRP_ASSERT_HOLDS(a_back_queued_range, queued_r <= CW'(RING_SLOTS), "queued count beyond ring")
  `ADRP_ASSERT_HOLDS(a_back_fill_range, 32'(fill_r) < 32'(SLOT_BYTES), "partial slot holds a full slot")
  `ADRP_ASSERT_HOLDS(a_back_ptr_range, (32'(retire_r) < 32'(RING_SLOTS)) && (32'(fslot_r) < 32'(RING_SLOTS)), "ring pointer out of range")

endmodule

`default_nettype wire
